// ===== rtl/core/bbor_pkg.sv =====
// Shared types and codes for the block buffer with overflow ring.
`default_nettype none

package bbor_pkg;

    localparam int ROFF_W = 9;

    typedef enum logic [1:0] {
        MODE_WRITE   = 2'd0,
        MODE_READ    = 2'd1,
        MODE_RELEASE = 2'd2,
        MODE_PAD     = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        PUT_INPUT,
        PUT_RING,
        PUT_ZERO
    } t_put_src;

    typedef struct packed {
        t_mode             mode;
        logic [7:0]        data_byte;
        logic [ROFF_W-1:0] read_offset;
    } t_in_item;

    typedef struct packed {
        logic       accepted;
        logic [7:0] read_data;
        logic [1:0] full_blocks;
        logic [8:0] fill_level;
        logic [9:0] overflow_level;
    } t_out_item;

    typedef struct packed {
        logic     latch;
        logic     put;
        t_put_src put_src;
        logic     ring_push;
        logic     ring_pop;
        logic     ring_rd;
        logic     blk_rd;
        logic     roff_sub;
        logic     release_blk;
        logic     set_acc;
        logic     cap_read;
    } t_dp_cmd;

    typedef struct packed {
        logic ring_empty;
        logic ring_full;
        logic all_full;
        logic any_full;
        logic roff_ge;
        logic fill_last;
        logic fill_empty;
    } t_dp_status;

endpackage

`default_nettype wire

// ===== rtl/core/bbor_ctrl.sv =====
// Sequencer that steps each command through the buffer datapath.
`default_nettype none

module bbor_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 start,
    input  bbor_pkg::t_mode     i_mode,
    input  bbor_pkg::t_dp_status i_status,
    output bbor_pkg::t_dp_cmd   o_cmd,
    output logic                busy,
    output logic                o_done
);
    import bbor_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DRAIN_RD,
        ST_DRAIN_WR,
        ST_WR_PLACE,
        ST_RD_MOD,
        ST_RD_WAIT,
        ST_REL,
        ST_PAD
    } t_state;

    t_state r_state, n_state;
    logic   r_after_write, n_after_write;
    logic   r_done, n_done;
    t_dp_cmd cmd;

    always_comb begin
        cmd           = '0;
        cmd.put_src   = PUT_INPUT;
        n_state       = r_state;
        n_after_write = r_after_write;
        n_done        = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    cmd.latch = 1'b1;
                    case (i_mode)
                        MODE_WRITE: begin
                            n_state       = ST_DRAIN_RD;
                            n_after_write = 1'b1;
                        end
                        MODE_READ:    n_state = ST_RD_MOD;
                        MODE_RELEASE: n_state = ST_REL;
                        default:      n_state = ST_PAD;
                    endcase
                end
            end
            ST_DRAIN_RD: begin
                // Ring bytes move into free buffers before anything else lands.
                if (!i_status.ring_empty && !i_status.all_full) begin
                    cmd.ring_rd = 1'b1;
                    n_state     = ST_DRAIN_WR;
                end else if (r_after_write) begin
                    n_state = ST_WR_PLACE;
                end else begin
                    n_state = ST_IDLE;
                    n_done  = 1'b1;
                end
            end
            ST_DRAIN_WR: begin
                cmd.put      = 1'b1;
                cmd.put_src  = PUT_RING;
                cmd.ring_pop = 1'b1;
                n_state      = ST_DRAIN_RD;
            end
            ST_WR_PLACE: begin
                if (!i_status.all_full) begin
                    cmd.put     = 1'b1;
                    cmd.set_acc = 1'b1;
                end else if (!i_status.ring_full) begin
                    cmd.ring_push = 1'b1;
                    cmd.set_acc   = 1'b1;
                end
                n_state = ST_IDLE;
                n_done  = 1'b1;
            end
            ST_RD_MOD: begin
                if (i_status.roff_ge) begin
                    cmd.roff_sub = 1'b1;
                end else begin
                    cmd.blk_rd = 1'b1;
                    n_state    = ST_RD_WAIT;
                end
            end
            ST_RD_WAIT: begin
                cmd.cap_read = 1'b1;
                n_state      = ST_IDLE;
                n_done       = 1'b1;
            end
            ST_REL: begin
                if (i_status.any_full) begin
                    cmd.release_blk = 1'b1;
                    cmd.set_acc     = 1'b1;
                    n_after_write   = 1'b0;
                    n_state         = ST_DRAIN_RD;
                end else begin
                    n_state = ST_IDLE;
                    n_done  = 1'b1;
                end
            end
            ST_PAD: begin
                // The first cycle decides; later cycles only write zeros.
                if (!r_after_write) begin
                    if (i_status.ring_empty && !i_status.fill_empty && !i_status.all_full) begin
                        cmd.set_acc   = 1'b1;
                        n_after_write = 1'b1;
                    end else begin
                        n_state = ST_IDLE;
                        n_done  = 1'b1;
                    end
                end else begin
                    cmd.put     = 1'b1;
                    cmd.put_src = PUT_ZERO;
                    if (i_status.fill_last) begin
                        n_state = ST_IDLE;
                        n_done  = 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        // Pad reuses the flag as its started mark, so clear it on entry.
        if (r_state == ST_IDLE && start && i_mode == MODE_PAD) begin
            n_after_write = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_after_write <= 1'b0;
            r_done        <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_after_write <= n_after_write;
            r_done        <= n_done;
        end
    end

    assign o_cmd  = cmd;
    assign busy   = (r_state != ST_IDLE);
    assign o_done = r_done;

endmodule

`default_nettype wire

// ===== rtl/core/bbor_datapath.sv =====
// Block buffers, overflow ring, their pointers and the result registers.
`default_nettype none

module bbor_datapath #(
    parameter int BLOCK_BYTES    = 512,
    parameter int BUFFER_COUNT   = 2,
    parameter int OVERFLOW_BYTES = 512
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  bbor_pkg::t_in_item    i_item,
    input  bbor_pkg::t_dp_cmd     i_cmd,
    output bbor_pkg::t_dp_status  o_status,
    output bbor_pkg::t_out_item   o_result
);
    import bbor_pkg::*;

    localparam int OFF_W = $clog2(BLOCK_BYTES);
    localparam int FB_W  = $clog2(BUFFER_COUNT);
    localparam int FC_W  = $clog2(BUFFER_COUNT + 1);
    localparam int RP_W  = $clog2(OVERFLOW_BYTES);
    localparam int RC_W  = $clog2(OVERFLOW_BYTES + 1);
    localparam int BA_W  = $clog2(BUFFER_COUNT * BLOCK_BYTES);
    localparam logic [BA_W-1:0] BLK_SIZE = BA_W'(BLOCK_BYTES);

    logic [7:0] blk_mem  [BUFFER_COUNT*BLOCK_BYTES];
    logic [7:0] ring_mem [OVERFLOW_BYTES];

    logic [FB_W-1:0]   r_fill_block, n_fill_block;
    logic [FB_W-1:0]   r_drain_block, n_drain_block;
    logic [FC_W-1:0]   r_full_count, n_full_count;
    logic [OFF_W-1:0]  r_fill_off, n_fill_off;
    logic [RP_W-1:0]   r_head, n_head;
    logic [RP_W-1:0]   r_tail, n_tail;
    logic [RC_W-1:0]   r_ring_count, n_ring_count;
    logic              r_accepted;
    logic [7:0]        r_read_data;
    logic [7:0]        r_data;
    logic [ROFF_W-1:0] r_roff;
    logic [7:0]        r_blk_rdata;
    logic [7:0]        r_ring_rdata;

    logic [7:0]      put_data;
    logic [BA_W-1:0] blk_waddr;
    logic [BA_W-1:0] blk_raddr;
    logic            fill_last;
    logic            all_full;
    logic [31:0]     full_ext;
    logic [31:0]     fill_ext;
    logic [31:0]     ring_ext;

    assign fill_last = (r_fill_off == OFF_W'(BLOCK_BYTES - 1));
    assign all_full  = (r_full_count == FC_W'(BUFFER_COUNT));

    always_comb begin
        case (i_cmd.put_src)
            PUT_INPUT: put_data = r_data;
            PUT_RING:  put_data = r_ring_rdata;
            default:   put_data = 8'd0;
        endcase
    end

    assign blk_waddr = BA_W'(r_fill_block) * BLK_SIZE + BA_W'(r_fill_off);
    assign blk_raddr = BA_W'(r_drain_block) * BLK_SIZE + BA_W'(r_roff);

    always_comb begin
        n_fill_block  = r_fill_block;
        n_drain_block = r_drain_block;
        n_full_count  = r_full_count;
        n_fill_off    = r_fill_off;
        n_head        = r_head;
        n_tail        = r_tail;
        n_ring_count  = r_ring_count;
        if (i_cmd.put) begin
            if (fill_last) begin
                // Block complete: mark it full and move filling to the next buffer.
                n_fill_off   = '0;
                n_full_count = r_full_count + FC_W'(1);
                n_fill_block = (r_fill_block == FB_W'(BUFFER_COUNT - 1)) ? '0
                             : r_fill_block + FB_W'(1);
            end else begin
                n_fill_off = r_fill_off + OFF_W'(1);
            end
        end
        if (i_cmd.release_blk) begin
            n_full_count  = r_full_count - FC_W'(1);
            n_drain_block = (r_drain_block == FB_W'(BUFFER_COUNT - 1)) ? '0
                          : r_drain_block + FB_W'(1);
        end
        if (i_cmd.ring_push) begin
            n_tail       = (r_tail == RP_W'(OVERFLOW_BYTES - 1)) ? '0 : r_tail + RP_W'(1);
            n_ring_count = r_ring_count + RC_W'(1);
        end
        if (i_cmd.ring_pop) begin
            n_head       = (r_head == RP_W'(OVERFLOW_BYTES - 1)) ? '0 : r_head + RP_W'(1);
            n_ring_count = r_ring_count - RC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_block  <= '0;
            r_drain_block <= '0;
            r_full_count  <= '0;
            r_fill_off    <= '0;
            r_head        <= '0;
            r_tail        <= '0;
            r_ring_count  <= '0;
            r_accepted    <= 1'b0;
            r_read_data   <= 8'd0;
        end else begin
            r_fill_block  <= n_fill_block;
            r_drain_block <= n_drain_block;
            r_full_count  <= n_full_count;
            r_fill_off    <= n_fill_off;
            r_head        <= n_head;
            r_tail        <= n_tail;
            r_ring_count  <= n_ring_count;
            if (i_cmd.latch) begin
                r_accepted  <= 1'b0;
                r_read_data <= 8'd0;
            end else begin
                if (i_cmd.set_acc) begin
                    r_accepted <= 1'b1;
                end
                if (i_cmd.cap_read) begin
                    r_read_data <= (r_full_count != '0) ? r_blk_rdata : 8'd0;
                end
            end
        end
    end

    // Beat payload; the read offset is reduced below the block size in place.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_data <= i_item.data_byte;
            r_roff <= i_item.read_offset;
        end else if (i_cmd.roff_sub) begin
            r_roff <= r_roff - ROFF_W'(BLOCK_BYTES);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.put) begin
            blk_mem[blk_waddr] <= put_data;
        end
        if (i_cmd.blk_rd) begin
            r_blk_rdata <= blk_mem[blk_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ring_push) begin
            ring_mem[r_tail] <= r_data;
        end
        if (i_cmd.ring_rd) begin
            r_ring_rdata <= ring_mem[r_head];
        end
    end

    assign o_status.ring_empty = (r_ring_count == '0);
    assign o_status.ring_full  = (r_ring_count == RC_W'(OVERFLOW_BYTES));
    assign o_status.all_full   = all_full;
    assign o_status.any_full   = (r_full_count != '0);
    assign o_status.roff_ge    = (32'(r_roff) >= 32'(BLOCK_BYTES));
    assign o_status.fill_last  = fill_last;
    assign o_status.fill_empty = (r_fill_off == '0);

    assign full_ext = 32'(r_full_count);
    assign fill_ext = 32'(r_fill_off);
    assign ring_ext = 32'(r_ring_count);

    assign o_result.accepted       = r_accepted;
    assign o_result.read_data      = r_read_data;
    assign o_result.full_blocks    = full_ext[1:0];
    assign o_result.fill_level     = fill_ext[8:0];
    assign o_result.overflow_level = ring_ext[9:0];

endmodule

`default_nettype wire

// ===== rtl/core/block_buffer_with_overflow_ring_core.sv =====
// Top level of the ping-pong block buffer with an overflow ring.
//
// A command beat is taken when start is high and busy is low; its result is
// shown for one cycle with o_done, and the receiver cannot stall it. Each
// beat is worked by a sequencer over single-port steps on the two memories.
// A read first subtracts BLOCK_BYTES from the offset until it is below the
// block size (never when BLOCK_BYTES is at least 512), then reads the byte.
// A write first moves ring bytes into free buffers, then places its byte;
// a release frees a block and moves ring bytes into the freed space, and a
// pad writes zero bytes to finish the block. A refused beat ends after its
// check. The next beat can be taken in the cycle its result shows.
`default_nettype none

module block_buffer_with_overflow_ring_core #(
    parameter int BLOCK_BYTES    = 512,
    parameter int BUFFER_COUNT   = 2,
    parameter int OVERFLOW_BYTES = 512
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  start,
    input  bbor_pkg::t_in_item   i_item,
    output logic                 busy,
    output logic                 o_done,
    output bbor_pkg::t_out_item  o_result
);
    import bbor_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    bbor_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_mode   (i_item.mode),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy),
        .o_done   (o_done)
    );

    bbor_datapath #(
        .BLOCK_BYTES    (BLOCK_BYTES),
        .BUFFER_COUNT   (BUFFER_COUNT),
        .OVERFLOW_BYTES (OVERFLOW_BYTES)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_status (status),
        .o_result (o_result)
    );

endmodule

`default_nettype wire
